// ----- hw/rtl/ulss_pkg.sv -----
// ----------------------------------------------------------------------------
// ulss_pkg
// Shared constants for the undervoltage and link safety supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package ulss_pkg;

    // Configuration register widths and port layout
    localparam int THR_BITS      = 16;
    localparam int TMO_BITS      = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WARNING   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOLD      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYST      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINK_TMO  = 3'd5;

    // Ladder stages
    typedef logic [1:0] stage_t;
    localparam stage_t STAGE_NONE   = 2'd0;
    localparam stage_t STAGE_WARN   = 2'd1;
    localparam stage_t STAGE_FOLD   = 2'd2;
    localparam stage_t STAGE_CUTOFF = 2'd3;

    // LED patterns
    typedef logic [1:0] led_t;
    localparam led_t LED_SLOW  = 2'd0;
    localparam led_t LED_SOLID = 2'd1;
    localparam led_t LED_FAST  = 2'd2;

    // Result item layout
    localparam int OUT_FIELD_BITS = 10;
    localparam int OUT_DATA_BITS  = 16;

endpackage : ulss_pkg

`default_nettype wire

// ----- hw/rtl/ulss_detector.sv -----
// ----------------------------------------------------------------------------
// ulss_detector
// One undervoltage detector: hold time below threshold, hysteresis to clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ulss_detector #(
    parameter int TIME_BITS = 48,
    parameter int VOLT_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [VOLT_BITS-1:0]           mv,
    input  wire logic [TIME_BITS-1:0]           now,
    input  wire logic [ulss_pkg::THR_BITS-1:0]  thr,
    input  wire logic [ulss_pkg::THR_BITS-1:0]  hyst,
    input  wire logic [ulss_pkg::TMO_BITS-1:0]  hold,
    output logic                                active_next
);
    import ulss_pkg::*;

    localparam int CMP_W = ((VOLT_BITS > THR_BITS) ? VOLT_BITS : THR_BITS) + 1;

    logic                 active_reg;
    logic                 timing_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic                 timing_next;
    logic [TIME_BITS-1:0] start_next;
    logic [CMP_W-1:0]     mv_ext;
    logic [CMP_W-1:0]     thr_ext;
    logic [CMP_W-1:0]     clear_level;
    logic [TIME_BITS-1:0] elapsed;
    logic                 det_active_n;

    assign mv_ext      = CMP_W'(mv);
    assign thr_ext     = CMP_W'(thr);
    assign clear_level = thr_ext + CMP_W'(hyst);
    // start of a new timing run reads as zero elapsed
    assign elapsed     = timing_reg ? (now - start_reg) : '0;

    always_comb
    begin
        det_active_n = active_reg;
        timing_next  = timing_reg;
        start_next   = start_reg;
        if (thr == '0)
        begin
            det_active_n = 1'b0;
            timing_next  = 1'b0;
        end
        else if (active_reg)
        begin
            if (mv_ext > clear_level)
            begin
                det_active_n = 1'b0;
                timing_next  = 1'b0;
            end
        end
        else if (mv_ext < thr_ext)
        begin
            if (!timing_reg)
            begin
                start_next = now;
            end
            timing_next = 1'b1;
            if (elapsed >= TIME_BITS'(hold))
            begin
                det_active_n = 1'b1;
            end
        end
        else
        begin
            timing_next = 1'b0;
        end
    end

    assign active_next = step ? det_active_n : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            timing_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (step)
        begin
            active_reg <= det_active_n;
            timing_reg <= timing_next;
            start_reg  <= start_next;
        end
    end

endmodule : ulss_detector

`default_nettype wire

// ----- hw/rtl/undervolt_link_safety_supervisor.sv -----
// ----------------------------------------------------------------------------
// undervolt_link_safety_supervisor
// Battery undervoltage ladder, link staleness and relay arming supervisor.
// ----------------------------------------------------------------------------
// Takes one observation item per clock and returns one decision item for each.
// An item is accepted into the input register, evaluated against the detector
// and ladder state in a single pass, and lands in the result register when
// that register advances. One item per cycle is sustained, limited only by
// the result register being taken downstream.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no item is in flight, which the block
// itself does not enforce. The stage ladder only rises and is cleared by reset.
`default_nettype none

module undervolt_link_safety_supervisor #(
    parameter int TIME_BITS = 48,
    parameter int VOLT_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ulss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [ulss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // battery_ok, battery_mv, now_time_us, link_up, last_frame_us,
    // is_folded, can_arm, ext_fault, is_walking, zero pad
    input  wire logic [((2*TIME_BITS+VOLT_BITS+6+7)/8)*8-1:0] s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // stale flag, zero-command flag, relay_on, stage[1:0], fold_request,
    // cutoff_now, fault_out, led_mode[1:0], zero pad
    output logic [ulss_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata
);
    import ulss_pkg::*;

    localparam int IN_W     = 2*TIME_BITS + VOLT_BITS + 6;
    localparam int OFS_MV   = 1;
    localparam int OFS_NOW  = OFS_MV + VOLT_BITS;
    localparam int OFS_LINK = OFS_NOW + TIME_BITS;
    localparam int OFS_LAST = OFS_LINK + 1;
    localparam int OFS_FLG  = OFS_LAST + TIME_BITS;

    // configuration
    logic [THR_BITS-1:0] warning_reg, fold_lvl_reg, cutoff_reg, hyst_reg;
    logic [TMO_BITS-1:0] hold_reg, link_tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warning_reg  <= '0;
            fold_lvl_reg <= '0;
            cutoff_reg   <= '0;
            hyst_reg     <= '0;
            hold_reg     <= '0;
            link_tmo_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WARNING:  warning_reg  <= cfg_data[THR_BITS-1:0];
                REG_FOLD:     fold_lvl_reg <= cfg_data[THR_BITS-1:0];
                REG_CUTOFF:   cutoff_reg   <= cfg_data[THR_BITS-1:0];
                REG_HYST:     hyst_reg     <= cfg_data[THR_BITS-1:0];
                REG_HOLD:     hold_reg     <= cfg_data[TMO_BITS-1:0];
                REG_LINK_TMO: link_tmo_reg <= cfg_data[TMO_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline control
    logic            in_valid_reg;
    logic [IN_W-1:0] in_data_reg;
    logic            out_valid_reg;
    logic            advance;
    logic            fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[IN_W-1:0];
        end
    end

    // field unpack
    logic                 battery_ok;
    logic [VOLT_BITS-1:0] battery_mv;
    logic [TIME_BITS-1:0] now_time_us;
    logic                 link_up;
    logic [TIME_BITS-1:0] last_frame_us;
    logic                 is_folded, can_arm, ext_fault, is_walking;

    assign battery_ok    = in_data_reg[0];
    assign battery_mv    = in_data_reg[OFS_NOW-1:OFS_MV];
    assign now_time_us   = in_data_reg[OFS_LINK-1:OFS_NOW];
    assign link_up       = in_data_reg[OFS_LINK];
    assign last_frame_us = in_data_reg[OFS_FLG-1:OFS_LAST];
    assign is_folded     = in_data_reg[OFS_FLG];
    assign can_arm       = in_data_reg[OFS_FLG+1];
    assign ext_fault     = in_data_reg[OFS_FLG+2];
    assign is_walking    = in_data_reg[OFS_FLG+3];

    // detectors: warning, fold, cutoff
    logic [2:0]          det_active;
    logic [THR_BITS-1:0] det_thr [3];

    assign det_thr[0] = warning_reg;
    assign det_thr[1] = fold_lvl_reg;
    assign det_thr[2] = cutoff_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_det
        ulss_detector #(
            .TIME_BITS (TIME_BITS),
            .VOLT_BITS (VOLT_BITS)
        ) u_det (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (fire && battery_ok),
            .mv          (battery_mv),
            .now         (now_time_us),
            .thr         (det_thr[k]),
            .hyst        (hyst_reg),
            .hold        (hold_reg),
            .active_next (det_active[k])
        );
    end

    // ladder and outputs
    stage_t stage_reg, stage_next, observed;
    logic   fold_sent_reg, prev_folded_reg, relay_reg, relay_next;
    logic   fold_req, b_warn, b_fold, b_cut, stale, fold_done, fz, fault;
    logic [TIME_BITS-1:0] link_age;
    led_t   led;

    always_comb
    begin
        observed = STAGE_NONE;
        if (det_active[0]) observed = STAGE_WARN;
        if (det_active[1]) observed = STAGE_FOLD;
        if (det_active[2]) observed = STAGE_CUTOFF;
    end

    assign stage_next = (observed > stage_reg) ? observed : stage_reg;
    assign b_warn     = stage_next >= STAGE_WARN;
    assign b_fold     = stage_next >= STAGE_FOLD;
    assign b_cut      = stage_next == STAGE_CUTOFF;
    assign fold_req   = b_fold && !fold_sent_reg;

    assign link_age   = now_time_us - last_frame_us;
    assign stale      = !link_up || (last_frame_us == '0)
                        || (link_age >= TIME_BITS'(link_tmo_reg));
    assign fold_done  = is_folded && !prev_folded_reg;

    always_comb
    begin
        relay_next = relay_reg;
        if (relay_reg)
        begin
            if (fold_done || b_cut || ext_fault)
            begin
                relay_next = 1'b0;
            end
        end
        else if (link_up && can_arm && !b_fold && !ext_fault)
        begin
            relay_next = 1'b1;
        end
    end

    assign fz    = stale || b_fold;
    assign fault = b_warn || (relay_next && !link_up) || ext_fault;

    always_comb
    begin
        if (fault)
        begin
            led = LED_FAST;
        end
        else if (link_up && is_walking && !fz)
        begin
            led = LED_SOLID;
        end
        else
        begin
            led = LED_SLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= STAGE_NONE;
            fold_sent_reg   <= 1'b0;
            prev_folded_reg <= 1'b0;
            relay_reg       <= 1'b0;
        end
        else if (fire)
        begin
            stage_reg       <= stage_next;
            fold_sent_reg   <= fold_sent_reg || fold_req;
            prev_folded_reg <= is_folded;
            relay_reg       <= relay_next;
        end
    end

    logic [OUT_FIELD_BITS-1:0] result_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= {led, fault, b_cut, fold_req, stage_next, relay_next, fz, stale};
        end
    end

    assign m_axis_tdata = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0), result_reg};

endmodule : undervolt_link_safety_supervisor

`default_nettype wire

// ----- hw/rtl/ulss_checker.sv -----
// ----------------------------------------------------------------------------
// ulss_checker
// Port-level checks on the supervisor result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ulss_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [ulss_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import ulss_pkg::*;

    logic   stale, fz, cut, fault;
    stage_t stage;
    led_t   led;

    assign stale = m_axis_tdata[0];
    assign fz    = m_axis_tdata[1];
    assign stage = m_axis_tdata[4:3];
    assign cut   = m_axis_tdata[6];
    assign fault = m_axis_tdata[7];
    assign led   = m_axis_tdata[9:8];

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (cut == (stage == STAGE_CUTOFF)))
        else $error("cutoff_now disagrees with stage");

    a_zero_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (fz == (stale || stage >= STAGE_FOLD)))
        else $error("zero-command flag disagrees with staleness and stage");

    a_fault_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((led == LED_FAST) == fault))
        else $error("led pattern disagrees with fault");

    a_warn_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && stage != STAGE_NONE |-> fault)
        else $error("ladder stage without fault");

endmodule : ulss_checker

bind undervolt_link_safety_supervisor ulss_checker u_ulss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/ulss_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ulss_scoreboard
// Watches the observation and decision streams of the undervoltage and link
// safety supervisor, predicts each decision from its own copy of the detector,
// ladder and relay state, and compares every decision field by field.
// ----------------------------------------------------------------------------

module ulss_scoreboard #(
    parameter int OBS_BITS = 120
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ulss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ulss_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               obs_valid,
    input  logic                               obs_ready,
    input  logic [OBS_BITS-1:0]                obs_data,
    input  logic                               dec_valid,
    input  logic                               dec_ready,
    input  logic [ulss_pkg::OUT_DATA_BITS-1:0] dec_data,
    output int                                 mismatches,
    output int                                 decisions_pending,
    output int                                 decisions_checked
);
    import ulss_pkg::*;

    typedef struct packed {
        logic   stale;
        logic   zero_cmd;
        logic   relay;
        stage_t stage;
        logic   fold_req;
        logic   cutoff;
        logic   fault;
        led_t   led;
    } decision_t;

    decision_t decisions_due [$];

    // shadow copy of the configuration registers
    logic [THR_BITS-1:0] warn_thr;
    logic [THR_BITS-1:0] fold_thr;
    logic [THR_BITS-1:0] cut_thr;
    logic [THR_BITS-1:0] hyst;
    logic [TMO_BITS-1:0] hold_us;
    logic [TMO_BITS-1:0] link_tmo_us;

    logic        det_active  [3];
    logic        det_timing  [3];
    logic [47:0] timer_start [3];
    stage_t      ladder;
    logic        fold_pulsed;
    logic        folded_seen;
    logic        armed;

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            report_mismatch($sformatf("mismatch in %s on decision %0d: expected %0d, got %0d",
                                      name, decisions_checked, want, got));
    endtask

    task automatic track_threshold(input int k, input logic [15:0] mv,
                                   input logic [47:0] now, input logic [15:0] thr);
        logic [16:0] clear_level;
        logic [47:0] elapsed;
        // sum is 17 bits wide so it never wraps
        clear_level = {1'b0, thr} + {1'b0, hyst};
        if (thr == '0)
        begin
            det_active[k] = 1'b0;
            det_timing[k] = 1'b0;
        end
        else if (det_active[k])
        begin
            if ({1'b0, mv} > clear_level)
            begin
                det_active[k] = 1'b0;
                det_timing[k] = 1'b0;
            end
        end
        else if (mv < thr)
        begin
            if (!det_timing[k])
            begin
                timer_start[k] = now;
                det_timing[k]  = 1'b1;
            end
            elapsed = now - timer_start[k];
            if (elapsed >= {16'b0, hold_us})
                det_active[k] = 1'b1;
        end
        else
            det_timing[k] = 1'b0;
    endtask

    task automatic judge_observation(input logic [OBS_BITS-1:0] d, output decision_t dec);
        logic        ok;
        logic [15:0] mv;
        logic [47:0] now;
        logic        link;
        logic [47:0] last;
        logic        folded;
        logic        arm_ok;
        logic        ext;
        logic        walk;
        logic [47:0] since_frame;
        stage_t      seen;
        logic        fold_done;
        logic        at_fold;
        ok     = d[0];
        mv     = d[16:1];
        now    = d[64:17];
        link   = d[65];
        last   = d[113:66];
        folded = d[114];
        arm_ok = d[115];
        ext    = d[116];
        walk   = d[117];

        // an invalid sample leaves every detector where it was
        if (ok)
        begin
            track_threshold(0, mv, now, warn_thr);
            track_threshold(1, mv, now, fold_thr);
            track_threshold(2, mv, now, cut_thr);
        end
        seen = STAGE_NONE;
        if (det_active[0])
            seen = STAGE_WARN;
        if (det_active[1])
            seen = STAGE_FOLD;
        if (det_active[2])
            seen = STAGE_CUTOFF;
        if (seen > ladder)
            ladder = seen;

        dec.fold_req = (ladder >= STAGE_FOLD) && !fold_pulsed;
        if (dec.fold_req)
            fold_pulsed = 1'b1;
        at_fold    = ladder >= STAGE_FOLD;
        dec.cutoff = ladder == STAGE_CUTOFF;
        dec.stage  = ladder;

        since_frame = now - last;
        dec.stale = !link || (last == '0) || (since_frame >= {16'b0, link_tmo_us});

        // of the folded flag only a rising edge disarms; cutoff and ext_fault disarm too
        fold_done   = folded && !folded_seen;
        folded_seen = folded;
        if (armed)
        begin
            if (fold_done || dec.cutoff || ext)
                armed = 1'b0;
        end
        else if (link && arm_ok && !at_fold && !ext)
            armed = 1'b1;

        dec.relay    = armed;
        dec.zero_cmd = dec.stale || at_fold;
        dec.fault    = (ladder != STAGE_NONE) || (armed && !link) || ext;
        if (dec.fault)
            dec.led = LED_FAST;
        else if (link && walk && !dec.zero_cmd)
            dec.led = LED_SOLID;
        else
            dec.led = LED_SLOW;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        decision_t due;
        decision_t fresh;
        if (!rst_n)
        begin
            decisions_due.delete();
            mismatches        = 0;
            decisions_pending = 0;
            decisions_checked = 0;
            warn_thr    = '0;
            fold_thr    = '0;
            cut_thr     = '0;
            hyst        = '0;
            hold_us     = '0;
            link_tmo_us = '0;
            for (int k = 0; k < 3; k++)
            begin
                det_active[k]  = 1'b0;
                det_timing[k]  = 1'b0;
                timer_start[k] = '0;
            end
            ladder      = STAGE_NONE;
            fold_pulsed = 1'b0;
            folded_seen = 1'b0;
            armed       = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WARNING:  warn_thr    = cfg_data[THR_BITS-1:0];
                    REG_FOLD:     fold_thr    = cfg_data[THR_BITS-1:0];
                    REG_CUTOFF:   cut_thr     = cfg_data[THR_BITS-1:0];
                    REG_HYST:     hyst        = cfg_data[THR_BITS-1:0];
                    REG_HOLD:     hold_us     = cfg_data[TMO_BITS-1:0];
                    REG_LINK_TMO: link_tmo_us = cfg_data[TMO_BITS-1:0];
                    default: ;
                endcase
            end

            // a decision leaving now belongs to an item taken at an earlier edge
            if (dec_valid && dec_ready)
            begin
                if (decisions_due.size() == 0)
                begin
                    report_mismatch("decision with no observation waiting");
                end
                else
                begin
                    due = decisions_due.pop_front();
                    decisions_pending--;
                    check_field("stale",        due.stale,    dec_data[0]);
                    check_field("zero_cmd",     due.zero_cmd, dec_data[1]);
                    check_field("relay_on",     due.relay,    dec_data[2]);
                    check_field("stage",        due.stage,    dec_data[4:3]);
                    check_field("fold_request", due.fold_req, dec_data[5]);
                    check_field("cutoff_now",   due.cutoff,   dec_data[6]);
                    check_field("fault_out",    due.fault,    dec_data[7]);
                    check_field("led_mode",     due.led,      dec_data[9:8]);
                    decisions_checked++;
                end
            end

            if (obs_valid && obs_ready)
            begin
                judge_observation(obs_data, fresh);
                decisions_due.push_back(fresh);
                decisions_pending++;
            end
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the undervoltage and link safety supervisor: link, relay and
// LED cases with the detectors off, a long gap-free run with the detectors
// timing but never firing, then the ladder walked from warning to cutoff,
// with the checker comparing every decision.
// ----------------------------------------------------------------------------

module testbench;
    import ulss_pkg::*;

    localparam int OBS_BITS    = ((2 * 48 + 16 + 6 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {GEN_LINK, GEN_QUIET, GEN_LADDER} gen_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // battery_ok, battery_mv, now_time_us, link_up, last_frame_us,
    // is_folded, can_arm, ext_fault, is_walking, zero pad
    logic [OBS_BITS-1:0]      s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // stale flag, zero-command flag, relay_on, stage[1:0], fold_request,
    // cutoff_now, fault_out, led_mode[1:0], zero pad
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    int mismatches;
    int decisions_pending;
    int decisions_checked;

    int          cycle_count = 0;
    int          observations_sent = 0;
    int          settings_used = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    logic [47:0] clock_us = '0;
    logic [47:0] base_us;
    logic        folded_now = 1'b0;
    logic [15:0] warn_lvl = '0;
    logic [15:0] fold_lvl = '0;
    logic [15:0] cut_lvl = '0;
    logic [15:0] hyst_lvl = '0;
    logic [31:0] tmo_us = '0;

    undervolt_link_safety_supervisor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ulss_scoreboard #(.OBS_BITS(OBS_BITS)) scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .obs_valid         (s_axis_tvalid),
        .obs_ready         (s_axis_tready),
        .obs_data          (s_axis_tdata),
        .dec_valid         (m_axis_tvalid),
        .dec_ready         (m_axis_tready),
        .dec_data          (m_axis_tdata),
        .mismatches        (mismatches),
        .decisions_pending (decisions_pending),
        .decisions_checked (decisions_checked)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 12);
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    task automatic offer_observation(input logic ok, input logic [15:0] mv,
                                     input logic [47:0] now, input logic link,
                                     input logic [47:0] last, input logic folded,
                                     input logic arm_ok, input logic ext,
                                     input logic walk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, walk, ext, arm_ok, folded, last, link, now, mv, ok};
        do
            @(posedge clk);
        while (!s_axis_tready);
        observations_sent++;
        if (!tx_steady && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // drain the pipeline, then rewrite every register
    task automatic apply_settings(input logic [15:0] w, input logic [15:0] f,
                                  input logic [15:0] c, input logic [15:0] h,
                                  input logic [31:0] hold, input logic [31:0] tmo);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decisions_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_WARNING,  {16'b0, w});
        write_reg(REG_FOLD,     {16'b0, f});
        write_reg(REG_CUTOFF,   {16'b0, c});
        write_reg(REG_HYST,     {16'b0, h});
        write_reg(REG_HOLD,     hold);
        write_reg(REG_LINK_TMO, tmo);
        cfg_we   <= 1'b0;
        warn_lvl = w;
        fold_lvl = f;
        cut_lvl  = c;
        hyst_lvl = h;
        tmo_us   = tmo;
        settings_used++;
    endtask

    task automatic offer_random(input gen_mode_t mode);
        int unsigned r;
        int unsigned span;
        int          lvl;
        logic [15:0] thr;
        logic [15:0] mv;
        logic [47:0] last;

        r = $urandom_range(0, 99);
        if (mode == GEN_LINK)
        begin
            if (r < 70)
                clock_us = clock_us + 48'($urandom_range(0, 3000));
            else if (r < 80)
                clock_us = clock_us + 48'($urandom());
            else if (r < 88)
                clock_us = clock_us - 48'($urandom_range(1, 5000));
            else
                clock_us = rand48();
        end
        else if (mode == GEN_LADDER && r < 3)
            clock_us = clock_us - 48'($urandom_range(1, 100));   // clock runs backwards
        else
            clock_us = clock_us + 48'($urandom_range(0, 1500));

        span = (tmo_us == 0 || tmo_us > 32'd100000) ? 3000 : 2 * tmo_us;
        r = $urandom_range(0, 99);
        if (r < 55)
            last = clock_us - 48'($urandom_range(0, span));
        else if (r < 65)
            last = clock_us - {16'b0, tmo_us};
        else if (r < 75)
            last = '0;
        else if (r < 85)
            last = rand48();
        else if (r < 92)
            last = clock_us;
        else
            last = clock_us + 48'($urandom_range(1, 1000));

        r = $urandom_range(0, 99);
        if (mode == GEN_LADDER)
        begin
            case ($urandom_range(0, 2))
                0:       thr = warn_lvl;
                1:       thr = fold_lvl;
                default: thr = cut_lvl;
            endcase
            if (thr == '0)
                thr = warn_lvl;
            if (r < 60)
                lvl = int'(thr) + int'($urandom_range(0, 1600)) - 800;
            else if (r < 70)
                lvl = int'(thr) + int'(hyst_lvl);
            else if (r < 78)
                lvl = int'(thr) + int'(hyst_lvl) + 1;
            else if (r < 86)
                lvl = int'(thr) - 1;
            else
                lvl = int'($urandom_range(0, 65535));
            if (lvl < 0)
                lvl = 0;
            if (lvl > 65535)
                lvl = 65535;
            mv = lvl[15:0];
        end
        else if (r < 10)
            mv = 16'h0000;
        else if (r < 20)
            mv = 16'hFFFF;
        else
            mv = 16'($urandom_range(0, 65535));

        if ($urandom_range(0, 99) < 15)
            folded_now = ~folded_now;

        offer_observation($urandom_range(0, 99) < 90, mv, clock_us,
                          $urandom_range(0, 99) < 85, last, folded_now,
                          $urandom_range(0, 1) == 1, $urandom_range(0, 99) < 4,
                          $urandom_range(0, 1) == 1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // link, relay and LED cases with all detectors off
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1000);
        offer_observation(0, 16'h0000, 48'd0,    0, 48'd0,    0, 0, 0, 0);
        offer_observation(1, 16'hFFFF, 48'd1000, 1, 48'd0,    0, 1, 0, 0); // no frame yet
        offer_observation(1, 16'd12000, 48'd2000, 1, 48'd1500, 0, 1, 0, 1);
        offer_observation(1, 16'd12000, 48'd2500, 1, 48'd1500, 0, 0, 0, 1); // exactly timeout
        offer_observation(1, 16'd12000, 48'd2700, 0, 48'd2600, 0, 0, 0, 1); // link lost, armed
        offer_observation(1, 16'd12000, 48'd2800, 1, 48'd2700, 1, 1, 0, 0); // fold edge
        offer_observation(1, 16'd12000, 48'd2900, 1, 48'd2800, 1, 1, 0, 0); // held fold
        offer_observation(1, 16'd12000, 48'd3000, 1, 48'd2900, 0, 1, 1, 1);
        offer_observation(1, 16'd12000, 48'd3100, 1, 48'd3000, 0, 1, 0, 1);
        offer_observation(1, 16'd0, 48'hFFFF_FFFF_FFFF, 1, 48'hFFFF_FFFF_FF9B, 1, 1, 1, 1);
        offer_observation(1, 16'h5555, 48'd50, 1, 48'hFFFF_FFFF_FF9B, 0, 0, 0, 1); // wrapped
        offer_observation(1, 16'hAAAA, 48'd10, 1, 48'd20, 0, 1, 0, 1); // frame in the future
        offer_observation(0, 16'h1234, 48'd20, 1, 48'd20, 0, 0, 0, 0);

        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        repeat (100) offer_random(GEN_LINK);
        apply_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (100) offer_random(GEN_LINK);
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'($urandom_range(100, 20000)));
        repeat (300) offer_random(GEN_LINK);

        // detectors time but the hold is never reached; clock wraps early on
        apply_settings(16'd30000, 16'd25000, 16'd20000, 16'hFFFF, 32'hFFFF_FFFF, 32'd5000);
        clock_us  = 48'hFFFF_FFFF_0000;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (300) offer_random(GEN_QUIET);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // warning only: a dip shorter than the hold, one reaching it across an invalid sample, hysteresis
        apply_settings(16'd20000, 16'd0, 16'd0, 16'd500, 32'd3000, 32'd5000);
        base_us = clock_us;
        offer_observation(1, 16'd19999, base_us,          1, base_us - 48'd100, 0, 1, 0, 1);
        offer_observation(1, 16'd19000, base_us + 48'd1000, 1, base_us, 0, 1, 0, 1);
        offer_observation(1, 16'd20000, base_us + 48'd1500, 1, base_us, 0, 1, 0, 1);
        offer_observation(1, 16'd15000, base_us + 48'd2000, 1, base_us, 0, 1, 0, 1);
        offer_observation(0, 16'd0,     base_us + 48'd4000, 1, base_us, 0, 1, 0, 1);
        offer_observation(1, 16'd19999, base_us + 48'd5000, 1, base_us, 0, 1, 0, 1);
        offer_observation(1, 16'd20500, base_us + 48'd5100, 1, base_us, 0, 1, 0, 1);
        offer_observation(1, 16'd20501, base_us + 48'd5200, 1, base_us, 0, 1, 0, 1);
        clock_us = base_us + 48'd5200;
        repeat (150) offer_random(GEN_LADDER);

        // fold with zero hold: fires at once, request pulses one time
        apply_settings(16'd20000, 16'd15000, 16'd0, 16'd500, 32'd0, 32'd5000);
        offer_observation(1, 16'd14999, clock_us + 48'd100, 1, clock_us, 0, 1, 0, 0);
        offer_observation(1, 16'd14000, clock_us + 48'd200, 1, clock_us, 0, 1, 0, 0);
        clock_us = clock_us + 48'd200;
        repeat (150) offer_random(GEN_LADDER);

        // cutoff reached through a clock that steps backwards
        apply_settings(16'd20000, 16'd15000, 16'd10000, 16'hFFFF, 32'd2000, 32'd5000);
        offer_observation(1, 16'd9000, clock_us,          1, clock_us, 0, 1, 0, 1);
        offer_observation(1, 16'd9000, clock_us - 48'd1, 1, clock_us, 0, 1, 0, 1);
        repeat (150) offer_random(GEN_LADDER);

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0, 32'hFFFF_FFFF);
        repeat (75) offer_random(GEN_LADDER);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decisions_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d observations over %0d register settings, ladder taken up to cutoff.",
                 observations_sent, settings_used);
        $display("Compared %0d decisions field by field; %0d field errors.",
                 decisions_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ulss_pkg.sv
hw/rtl/ulss_detector.sv
hw/rtl/undervolt_link_safety_supervisor.sv
hw/rtl/ulss_checker.sv
dv/ulss_checker.sv
dv/testbench.sv
